@@ rtl/aket_pkg.sv @@
// Shared types and character constants for the cursor-key escape translator.
package aket_pkg;

  localparam int unsigned MaxKeys = 4;

  localparam logic [7:0] ChEsc     = 8'h1B;
  localparam logic [7:0] ChBracket = 8'h5B;
  localparam logic [7:0] ChTilde   = 8'h7E;

  localparam logic ModeByte    = 1'b0;
  localparam logic ModeTimeout = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] key_code;
    logic       last;
  } out_item_t;

  // One run of keys caused by a single input item.
  typedef struct packed {
    logic [MaxKeys-1:0][7:0] keys;
    logic [2:0]              num;
  } key_run_t;

endpackage

@@ rtl/ansi_key_escape_translator_core.sv @@
// Top level of the cursor-key escape translator: prefix tracker feeding a key run register.
//
// The input channel (in_valid_i, in_ready_o, in_item_i) carries one item per transfer:
// either a received terminal byte (mode 0) or an idle timeout (mode 1). The output
// channel (out_valid_o, out_ready_i, out_item_o) carries one key code per transfer,
// with last set on the final key caused by an input item. An item may cause zero to
// four keys: plain bytes pass through, ESC [ X and ESC [ d ~ collapse into a single
// control code, and a broken or timed-out prefix is released as its raw bytes.
// The keys of an item accepted at one edge are offered from the next cycle on. An
// item that yields one key or none can be accepted every cycle while the receiver
// keeps taking keys; an item yielding more keys holds the result register until
// they have all transferred, so the next item is taken in the cycle its last key
// transfers. The key run register is the only thing that sets this rate.
// When the receiver stalls, the current key holds steady and in_ready_o stays low
// for as long as the register holds a key that has not yet transferred. Reset
// clears the pending prefix and empties the result register.
module ansi_key_escape_translator_core
  import aket_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic     accept;
  logic     can_load;
  key_run_t run;

  // The tracker decodes the incoming item against the pending prefix right at the
  // transfer, and the resulting run lands in the result register at the same edge.
  assign in_ready_o = can_load;
  assign accept     = in_valid_i && can_load;

  aket_prefix_track u_prefix_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .run_o    (run)
  );

  // Items that produce no key only advance the prefix state; the register is
  // loaded only when there is something to send.
  aket_key_queue u_key_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && (run.num != 3'd0)),
    .run_i       (run),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ rtl/aket_prefix_track.sv @@
// Escape prefix tracker: holds the pending prefix and decodes each input item into a key run.
module aket_prefix_track
  import aket_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output key_run_t run_o
);

  localparam logic [1:0] PfxNone    = 2'd0;
  localparam logic [1:0] PfxEsc     = 2'd1;
  localparam logic [1:0] PfxBracket = 2'd2;
  localparam logic [1:0] PfxDigit   = 2'd3;

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] digit_q, digit_d;

  logic [7:0] b;
  logic       three_hit, four_hit;
  logic [7:0] three_code, stored_code;
  logic       broken;
  logic [1:0] rel_n;
  logic       single;
  logic [7:0] single_code;
  logic       append;

  assign b = item_i.rx_byte;

  always_comb begin
    three_hit  = 1'b1;
    three_code = 8'd0;
    unique case (b)
      8'h41:   three_code = 8'd16; // A
      8'h42:   three_code = 8'd14; // B
      8'h43:   three_code = 8'd6;  // C
      8'h44:   three_code = 8'd2;  // D
      8'h46:   three_code = 8'd5;  // F
      8'h48:   three_code = 8'd1;  // H
      8'h34:   three_code = 8'd4;  // 4
      default: three_hit  = 1'b0;
    endcase
  end

  always_comb begin
    unique case (b)
      8'h31, 8'h33, 8'h35, 8'h36: four_hit = 1'b1;
      default:                    four_hit = 1'b0;
    endcase
  end

  // In the digit state the stored digit is always one of the four valid digits.
  always_comb begin
    unique case (digit_q)
      8'h31:   stored_code = 8'd1;
      8'h33:   stored_code = 8'd4;
      8'h35:   stored_code = 8'd7;
      8'h36:   stored_code = 8'd3;
      default: stored_code = 8'd0;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    digit_d     = digit_q;
    broken      = 1'b0;
    rel_n       = 2'd0;
    single      = 1'b0;
    single_code = 8'd0;
    append      = 1'b0;
    run_o.num   = 3'd0;

    if (item_i.mode == ModeTimeout) begin
      rel_n     = cnt_q;
      run_o.num = {1'b0, cnt_q};
      cnt_d     = PfxNone;
    end else begin
      unique case (cnt_q)
        PfxNone: begin
          broken = 1'b1;
        end
        PfxEsc: begin
          if (b == ChBracket) begin
            cnt_d = PfxBracket;
          end else begin
            broken = 1'b1;
            rel_n  = 2'd1;
          end
        end
        PfxBracket: begin
          if (three_hit) begin
            single      = 1'b1;
            single_code = three_code;
            cnt_d       = PfxNone;
          end else if (four_hit) begin
            digit_d = b;
            cnt_d   = PfxDigit;
          end else begin
            broken = 1'b1;
            rel_n  = 2'd2;
          end
        end
        default: begin
          if (b == ChTilde) begin
            single      = 1'b1;
            single_code = stored_code;
            cnt_d       = PfxNone;
          end else begin
            broken = 1'b1;
            rel_n  = 2'd3;
          end
        end
      endcase

      if (single) begin
        run_o.num = 3'd1;
      end else if (broken) begin
        // Release the pending bytes, then treat the byte as fresh.
        if (b == ChEsc) begin
          run_o.num = {1'b0, rel_n};
          cnt_d     = PfxEsc;
        end else begin
          run_o.num = {1'b0, rel_n} + 3'd1;
          append    = 1'b1;
          cnt_d     = PfxNone;
        end
      end
    end

    run_o.keys[0] = ChEsc;
    run_o.keys[1] = ChBracket;
    run_o.keys[2] = digit_q;
    run_o.keys[3] = b;
    if (append) begin
      run_o.keys[rel_n] = b;
    end
    if (single) begin
      run_o.keys[0] = single_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= PfxNone;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      digit_q <= digit_d;
    end
  end

endmodule

@@ rtl/aket_key_queue.sv @@
// Result register: holds one key run and hands its keys out one transfer at a time.
module aket_key_queue
  import aket_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  key_run_t  run_i,
  output logic      can_load_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [MaxKeys-1:0][7:0] keys_q;
  logic [2:0]              left_q;
  logic [1:0]              idx_q;
  logic                    pop;

  assign out_valid_o         = (left_q != 3'd0);
  assign pop                 = out_valid_o && out_ready_i;
  assign can_load_o          = (left_q == 3'd0) || (pop && (left_q == 3'd1));
  assign out_item_o.key_code = keys_q[idx_q];
  assign out_item_o.last     = (left_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= 3'd0;
      idx_q  <= 2'd0;
    end else if (load_i) begin
      left_q <= run_i.num;
      idx_q  <= 2'd0;
    end else if (pop) begin
      left_q <= left_q - 3'd1;
      idx_q  <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      keys_q <= run_i.keys;
    end
  end

endmodule

@@ sim/ansi_key_escape_translator_core_tb.sv @@
// Self-checking testbench for the cursor-key escape translator core.
module ansi_key_escape_translator_core_tb;
  import aket_pkg::*;

  // Control codes that the finished escape sequences collapse into.
  localparam logic [7:0] CodeHome     = 8'd1;
  localparam logic [7:0] CodeLeft     = 8'd2;
  localparam logic [7:0] CodePageDown = 8'd3;
  localparam logic [7:0] CodeDelete   = 8'd4;
  localparam logic [7:0] CodeEnd      = 8'd5;
  localparam logic [7:0] CodeRight    = 8'd6;
  localparam logic [7:0] CodePageUp   = 8'd7;
  localparam logic [7:0] CodeDown     = 8'd14;
  localparam logic [7:0] CodeUp       = 8'd16;

  localparam int RandomItems = 250;
  localparam int MaxReported = 10;

  logic      clk;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  ansi_key_escape_translator_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run: up to 278 items, each with up to four
  // keys that each wait out the longest receiver stall, plus the longest sender gaps.
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Key prediction. The pending escape prefix is tracked here exactly as the
  // block is expected to track it; every accepted item appends the keys it
  // causes to pending_keys, the last of them flagged.
  // ---------------------------------------------------------------------------
  logic [7:0] prefix_buf [3];
  logic [1:0] prefix_len = 2'd0;
  logic [7:0] key_run [$];
  out_item_t  pending_keys [$];
  int         key_errors = 0;
  int         items_sent = 0;
  bit         tx_steady  = 1'b0;

  function bit is_cursor_final(logic [7:0] b);
    return b inside {"A", "B", "C", "D", "F", "H", "4"};
  endfunction

  function logic [7:0] cursor_code(logic [7:0] b);
    case (b)
      "A":     return CodeUp;
      "B":     return CodeDown;
      "C":     return CodeRight;
      "D":     return CodeLeft;
      "F":     return CodeEnd;
      "H":     return CodeHome;
      default: return CodeDelete;
    endcase
  endfunction

  function bit is_tilde_digit(logic [7:0] b);
    return b inside {"1", "3", "5", "6"};
  endfunction

  function logic [7:0] tilde_code(logic [7:0] d);
    case (d)
      "1":     return CodeHome;
      "3":     return CodeDelete;
      "5":     return CodePageUp;
      default: return CodePageDown;
    endcase
  endfunction

  // A broken or timed-out prefix comes out as its raw bytes, oldest first.
  function void release_prefix();
    for (int k = 0; k < prefix_len; k++) key_run.push_back(prefix_buf[k]);
    prefix_len = 2'd0;
  endfunction

  // Byte arriving with nothing pending: ESC opens a prefix, anything else passes.
  function void take_fresh(logic [7:0] b);
    if (b == ChEsc) begin
      prefix_buf[0] = b;
      prefix_len    = 2'd1;
    end else begin
      key_run.push_back(b);
    end
  endfunction

  function void predict_keys(in_item_t it);
    out_item_t k_exp;
    logic [7:0] b;
    b = it.rx_byte;
    key_run.delete();
    if (it.mode == ModeTimeout) begin
      release_prefix();
    end else begin
      case (prefix_len)
        2'd0: take_fresh(b);
        2'd1: begin
          if (b == ChBracket) begin
            prefix_buf[1] = b;
            prefix_len    = 2'd2;
          end else begin
            release_prefix();
            take_fresh(b);
          end
        end
        2'd2: begin
          // Digit 4 finishes at once; the other tilde digits wait for the tilde.
          if (is_cursor_final(b)) begin
            prefix_len = 2'd0;
            key_run.push_back(cursor_code(b));
          end else if (is_tilde_digit(b)) begin
            prefix_buf[2] = b;
            prefix_len    = 2'd3;
          end else begin
            release_prefix();
            take_fresh(b);
          end
        end
        default: begin
          if (b == ChTilde) begin
            prefix_len = 2'd0;
            key_run.push_back(tilde_code(prefix_buf[2]));
          end else begin
            release_prefix();
            take_fresh(b);
          end
        end
      endcase
    end
    foreach (key_run[i]) begin
      k_exp.key_code = key_run[i];
      k_exp.last     = (i == key_run.size() - 1);
      pending_keys.push_back(k_exp);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then a long one.
  // ---------------------------------------------------------------------------
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Receiver side: runs of ready separated by stalls of random length.
  initial begin
    int run_len;
    int stall;
    forever begin
      run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      out_ready <= 1'b1;
      repeat (run_len) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sending. Valid stays high after a transfer; the next call either moves the
  // next item in at the same edge or drops valid for a gap, so valid gets one
  // assignment per edge. Every caller sends its next item without letting time
  // pass in between.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic m, logic [7:0] b);
    in_item_t nxt;
    int gap;
    nxt.mode    = m;
    nxt.rx_byte = b;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= nxt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_keys(nxt);
    items_sent++;
  endtask

  // Stop offering items until every predicted key has been taken.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Checking of every key transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [8:0] exp_val, logic [8:0] act_val);
    key_errors++;
    if (key_errors <= MaxReported)
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_val, act_val);
  endtask

  always @(posedge clk) begin
    out_item_t k_exp;
    if (rst_n && out_valid && out_ready) begin
      if (pending_keys.size() == 0) begin
        report_mismatch("unexpected key", 9'h000, {1'b0, out_item.key_code});
      end else begin
        k_exp = pending_keys.pop_front();
        if (out_item.key_code !== k_exp.key_code)
          report_mismatch("key_code", {1'b0, k_exp.key_code}, {1'b0, out_item.key_code});
        if (out_item.last !== k_exp.last)
          report_mismatch("last", {8'h00, k_exp.last}, {8'h00, out_item.last});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  function logic [7:0] cursor_final(int idx);
    case (idx)
      0:       return "A";
      1:       return "B";
      2:       return "C";
      3:       return "D";
      4:       return "F";
      5:       return "H";
      default: return "4";
    endcase
  endfunction

  function logic [7:0] tilde_digit(int idx);
    case (idx)
      0:       return "1";
      1:       return "3";
      2:       return "5";
      default: return "6";
    endcase
  endfunction

  // Random byte leaning on the characters that steer the prefix tracker.
  function logic [7:0] noise_byte();
    case ($urandom_range(0, 9))
      0:       return ChEsc;
      1:       return ChBracket;
      2:       return ChTilde;
      3:       return cursor_final($urandom_range(0, 6));
      4:       return tilde_digit($urandom_range(0, 3));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Opening part of a sequence: ESC, then the bracket, then a tilde digit.
  task automatic send_prefix(int len);
    if (len >= 1) send_item(ModeByte, ChEsc);
    if (len >= 2) send_item(ModeByte, ChBracket);
    if (len >= 3) send_item(ModeByte, tilde_digit($urandom_range(0, 3)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Both ends of the byte range pass straight through.
  task automatic test_plain_bytes();
    send_item(ModeByte, 8'h00);
    send_item(ModeByte, 8'hFF);
  endtask

  // Three-byte cursor keys, including digit 4, which finishes without a tilde.
  task automatic test_cursor_keys();
    send_prefix(2);
    send_item(ModeByte, "A");
    send_prefix(2);
    send_item(ModeByte, "4");
  endtask

  // Four-byte form with the closing tilde.
  task automatic test_tilde_keys();
    send_prefix(2);
    send_item(ModeByte, "1");
    send_item(ModeByte, ChTilde);
  endtask

  // A prefix that stops matching is released raw, then the breaking byte is handled;
  // the full four-byte release comes from ESC [ 6 followed by a non-tilde.
  task automatic test_broken_prefix();
    send_prefix(2);
    send_item(ModeByte, "6");
    send_item(ModeByte, "z");
    send_item(ModeByte, ChEsc);
    send_item(ModeByte, "q");
  endtask

  // Timeouts: with nothing pending they give nothing and the byte is ignored;
  // otherwise the pending prefix comes out raw.
  task automatic test_idle_timeout();
    send_item(ModeTimeout, 8'hFF);
    send_prefix(2);
    send_item(ModeByte, "3");
    send_item(ModeTimeout, 8'h00);
    send_item(ModeByte, ChEsc);
    send_item(ModeTimeout, ChBracket);
  endtask

  // Plain bytes and well-formed sequences with random content, mixed with broken
  // sequences, timeouts and noise. Halfway through, the sender waits for a
  // complete drain before it carries on.
  task automatic test_random_stream();
    int start;
    int kind;
    bit drained;
    start   = items_sent;
    drained = 1'b0;
    while (items_sent - start < RandomItems) begin
      if (!drained && items_sent - start >= RandomItems / 2) begin
        hold_until_drained();
        drained = 1'b1;
      end
      tx_steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        send_item(ModeByte, 8'($urandom_range(0, 255)));
      end else if (kind < 42) begin
        send_prefix(2);
        send_item(ModeByte, cursor_final($urandom_range(0, 6)));
      end else if (kind < 62) begin
        send_prefix(3);
        send_item(ModeByte, ChTilde);
      end else if (kind < 80) begin
        send_prefix($urandom_range(1, 3));
        send_item(ModeByte, noise_byte());
      end else if (kind < 90) begin
        send_prefix($urandom_range(0, 3));
        send_item(ModeTimeout, 8'($urandom_range(0, 255)));
      end else begin
        send_item(1'($urandom_range(0, 1)), noise_byte());
      end
    end
    tx_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_bytes();
    test_cursor_keys();
    test_tilde_keys();
    test_broken_prefix();
    test_idle_timeout();
    hold_until_drained();
    test_random_stream();

    // Wait for the last keys, then give any stray output time to show up.
    hold_until_drained();
    repeat (20) @(posedge clk);

    if (key_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ ansi_key_escape_translator_core.f @@
rtl/aket_pkg.sv
rtl/aket_prefix_track.sv
rtl/aket_key_queue.sv
rtl/ansi_key_escape_translator_core.sv
sim/ansi_key_escape_translator_core_tb.sv
